// File: rtl/core/chacha_pkg.sv
// ----------------------------------------------------------------------------
// chacha_pkg
// Types, constants and round functions shared by the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package chacha_pkg;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam int QUEUE_DEPTH = 8;
	localparam int WORDS_PER_BLOCK = 8;
	localparam int POS_W = $clog2(WORDS_PER_BLOCK);

	typedef enum logic [2:0] {
		REG_KEY0       = 3'd0,
		REG_KEY1       = 3'd1,
		REG_KEY2       = 3'd2,
		REG_KEY3       = 3'd3,
		REG_NONCE_LOW  = 3'd4,
		REG_NONCE_HIGH = 3'd5,
		REG_INIT_CTR   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_RUN,
		CORE_DONE
	} core_state_t;

	typedef struct packed {
		logic [63:0] text_in;
		logic [3:0]  valid_bytes;
		logic        first;
		logic        last;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] text_out;
		logic [3:0]  out_bytes;
		logic        out_last;
	} out_beat_t;

	typedef struct packed {
		logic [63:0]      text;
		logic [3:0]       nbytes;
		logic             last;
		logic [POS_W-1:0] pos;
		logic             new_block;
	} q_entry_t;

	typedef logic [15:0][31:0] word_state_t;
	typedef logic [WORDS_PER_BLOCK-1:0][63:0] ks_block_t;

	typedef struct packed {
		logic        start;
		logic [31:0] counter;
	} core_req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [3:0][31:0] quarter(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] a1, b1, c1, d1;
		logic [3:0][31:0] r;
		a1 = a + b;    d1 = rotl(d ^ a1, 16);
		c1 = c + d1;   b1 = rotl(b ^ c1, 12);
		a1 = a1 + b1;  d1 = rotl(d1 ^ a1, 8);
		c1 = c1 + d1;  b1 = rotl(b1 ^ c1, 7);
		r[0] = a1;
		r[1] = b1;
		r[2] = c1;
		r[3] = d1;
		return r;
	endfunction

	function automatic word_state_t half_round(input word_state_t s, input logic diag);
		word_state_t r;
		logic [3:0][31:0] q0, q1, q2, q3;
		if (!diag) begin
			q0 = quarter(s[0], s[4], s[8],  s[12]);
			q1 = quarter(s[1], s[5], s[9],  s[13]);
			q2 = quarter(s[2], s[6], s[10], s[14]);
			q3 = quarter(s[3], s[7], s[11], s[15]);
			r[0] = q0[0]; r[4] = q0[1]; r[8]  = q0[2]; r[12] = q0[3];
			r[1] = q1[0]; r[5] = q1[1]; r[9]  = q1[2]; r[13] = q1[3];
			r[2] = q2[0]; r[6] = q2[1]; r[10] = q2[2]; r[14] = q2[3];
			r[3] = q3[0]; r[7] = q3[1]; r[11] = q3[2]; r[15] = q3[3];
		end else begin
			q0 = quarter(s[0], s[5], s[10], s[15]);
			q1 = quarter(s[1], s[6], s[11], s[12]);
			q2 = quarter(s[2], s[7], s[8],  s[13]);
			q3 = quarter(s[3], s[4], s[9],  s[14]);
			r[0] = q0[0]; r[5] = q0[1]; r[10] = q0[2]; r[15] = q0[3];
			r[1] = q1[0]; r[6] = q1[1]; r[11] = q1[2]; r[12] = q1[3];
			r[2] = q2[0]; r[7] = q2[1]; r[8]  = q2[2]; r[13] = q2[3];
			r[3] = q3[0]; r[4] = q3[1]; r[9]  = q3[2]; r[14] = q3[3];
		end
		return r;
	endfunction

	function automatic logic [3:0] norm_bytes(input logic [3:0] n);
		logic [3:0] r;
		if (n == 4'd0) begin
			r = 4'd1;
		end else if (n > 4'd8) begin
			r = 4'd8;
		end else begin
			r = n;
		end
		return r;
	endfunction

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

// File: rtl/core/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 stream cipher over 64-bit message beats.
// Flow: an accepted beat is written into the queue and later popped into the
//   registered output; a beat that opens a new keystream block also waits
//   there until the round-iterative core (one column or diagonal round per
//   cycle) has finished that block, which serves up to 8 beats. The core
//   holds one block at a time; a new block starts once the back end takes it.
// Reset clears key, nonce, counter and position; keystream is loaded on use.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  chacha_pkg::in_beat_t  in_beat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output chacha_pkg::out_beat_t out_beat
);
	import chacha_pkg::*;

	logic [3:0][63:0] key_q;
	logic [63:0]      nonce_low_q;
	logic [31:0]      nonce_high_q;
	logic [31:0]      init_ctr_q;

	word_state_t base_state;
	core_req_t   core_req;
	core_stat_t  core_stat;
	ks_block_t   core_ks;
	logic        release_blk;
	logic        q_full;
	logic        q_push;
	q_entry_t    q_entry;
	q_entry_t    q_head;
	logic        q_not_empty;
	logic        q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q        <= '0;
			nonce_low_q  <= '0;
			nonce_high_q <= '0;
			init_ctr_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY0:       key_q[0]     <= cfg_data;
				REG_KEY1:       key_q[1]     <= cfg_data;
				REG_KEY2:       key_q[2]     <= cfg_data;
				REG_KEY3:       key_q[3]     <= cfg_data;
				REG_NONCE_LOW:  nonce_low_q  <= cfg_data;
				REG_NONCE_HIGH: nonce_high_q <= cfg_data[31:0];
				REG_INIT_CTR:   init_ctr_q   <= cfg_data[31:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		base_state[0]  = SIGMA0;
		base_state[1]  = SIGMA1;
		base_state[2]  = SIGMA2;
		base_state[3]  = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			base_state[4+2*i] = key_q[i][31:0];
			base_state[5+2*i] = key_q[i][63:32];
		end
		base_state[12] = '0;
		base_state[13] = nonce_low_q[31:0];
		base_state[14] = nonce_low_q[63:32];
		base_state[15] = nonce_high_q;
	end

	chacha_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_beat      (in_beat),
		.init_counter (init_ctr_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_entry),
		.core_req     (core_req),
		.core_stat    (core_stat)
	);

	chacha_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.entry_in  (q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty)
	);

	chacha_core #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_state  (base_state),
		.core_req    (core_req),
		.release_blk (release_blk),
		.core_stat   (core_stat),
		.core_ks     (core_ks)
	);

	chacha_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.not_empty   (q_not_empty),
		.pop         (q_pop),
		.core_stat   (core_stat),
		.core_ks     (core_ks),
		.release_blk (release_blk),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_beat    (out_beat)
	);

endmodule

// File: rtl/core/chacha_front.sv
// ----------------------------------------------------------------------------
// chacha_front
// Accepts message beats, tracks block counter and word position, requests
// keystream blocks and queues each beat for the back end.
// ----------------------------------------------------------------------------
module chacha_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  chacha_pkg::in_beat_t  in_beat,
	input  logic [31:0]           init_counter,
	input  logic                  q_full,
	output logic                  q_push,
	output chacha_pkg::q_entry_t  q_entry,
	output chacha_pkg::core_req_t core_req,
	input  chacha_pkg::core_stat_t core_stat
);
	import chacha_pkg::*;

	logic [31:0]      ctr_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      ctr_eff;
	logic [POS_W-1:0] pos_eff;
	logic             need_block;
	logic             accept;

	assign ctr_eff    = in_beat.first ? init_counter : ctr_q;
	assign pos_eff    = in_beat.first ? '0 : pos_q;
	assign need_block = (pos_eff == '0);
	assign in_ready   = !q_full && (!need_block || core_stat.idle);
	assign accept     = in_valid && in_ready;

	assign q_push            = accept;
	assign q_entry.text      = in_beat.text_in;
	assign q_entry.nbytes    = norm_bytes(in_beat.valid_bytes);
	assign q_entry.last      = in_beat.last;
	assign q_entry.pos       = pos_eff;
	assign q_entry.new_block = need_block;

	assign core_req.start   = accept && need_block;
	assign core_req.counter = ctr_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			ctr_q <= need_block ? ctr_eff + 32'd1 : ctr_eff;
			pos_q <= in_beat.last ? '0 : pos_eff + POS_W'(1);
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		core_req.start |-> core_stat.idle)
		else $error("block request while core busy");

	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_beat.first && !in_beat.last) |=> (pos_q == POS_W'(1)))
		else $error("position not restarted by first beat");

endmodule

// File: rtl/core/chacha_fifo.sv
// ----------------------------------------------------------------------------
// chacha_fifo
// Short queue of classified beats between front and back end.
// ----------------------------------------------------------------------------
module chacha_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  chacha_pkg::q_entry_t entry_in,
	output logic                 full,
	input  logic                 pop,
	output chacha_pkg::q_entry_t head,
	output logic                 not_empty
);
	import chacha_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t         mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");

endmodule

// File: rtl/core/chacha_core.sv
// ----------------------------------------------------------------------------
// chacha_core
// Round-iterative block function: one column or diagonal round per cycle,
// holds the finished keystream block until the back end takes it.
// ----------------------------------------------------------------------------
module chacha_core #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  chacha_pkg::word_state_t base_state,
	input  chacha_pkg::core_req_t   core_req,
	input  logic                    release_blk,
	output chacha_pkg::core_stat_t  core_stat,
	output chacha_pkg::ks_block_t   core_ks
);
	import chacha_pkg::*;

	localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
	localparam int RND_W = $clog2(HALF_ROUNDS);

	core_state_t state_q, state_d;
	logic [RND_W-1:0] rnd_q;
	word_state_t      work_q;
	word_state_t      init_q;
	word_state_t      seed_state;
	logic             last_rnd;

	assign last_rnd = (rnd_q == RND_W'(HALF_ROUNDS - 1));

	always_comb begin
		seed_state     = base_state;
		seed_state[12] = core_req.counter;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CORE_IDLE: if (core_req.start) state_d = CORE_RUN;
			CORE_RUN:  if (last_rnd) state_d = CORE_DONE;
			CORE_DONE: if (release_blk) state_d = CORE_IDLE;
			default:   state_d = CORE_IDLE;
		endcase
	end

	always_comb begin
		core_stat.idle = 1'b0;
		core_stat.done = 1'b0;
		unique case (state_q)
			CORE_IDLE: core_stat.idle = 1'b1;
			CORE_RUN:  ;
			CORE_DONE: core_stat.done = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CORE_IDLE) begin
				rnd_q <= '0;
			end else if (state_q == CORE_RUN) begin
				rnd_q <= rnd_q + RND_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CORE_IDLE && core_req.start) begin
			init_q <= seed_state;
			work_q <= seed_state;
		end else if (state_q == CORE_RUN) begin
			work_q <= half_round(work_q, rnd_q[0]);
		end
	end

	always_comb begin
		for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
			core_ks[i] = {work_q[2*i+1] + init_q[2*i+1], work_q[2*i] + init_q[2*i]};
		end
	end

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CORE_DONE && $past(state_q) != CORE_DONE) |-> $past(state_q) == CORE_RUN)
		else $error("block finished without rounds");

endmodule

// File: rtl/core/chacha_back.sv
// ----------------------------------------------------------------------------
// chacha_back
// Takes queued beats, loads keystream blocks from the core and drives the
// registered output channel.
// ----------------------------------------------------------------------------
module chacha_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  chacha_pkg::q_entry_t   head,
	input  logic                   not_empty,
	output logic                   pop,
	input  chacha_pkg::core_stat_t core_stat,
	input  chacha_pkg::ks_block_t  core_ks,
	output logic                   release_blk,
	output logic                   out_valid,
	input  logic                   out_ready,
	output chacha_pkg::out_beat_t  out_beat
);
	import chacha_pkg::*;

	ks_block_t   ks_q;
	logic        out_valid_q;
	out_beat_t   out_beat_q;
	logic [63:0] ks_word;

	assign pop         = not_empty && (!head.new_block || core_stat.done)
		&& (!out_valid_q || out_ready);
	assign release_blk = pop && head.new_block;
	assign ks_word     = head.new_block ? core_ks[0] : ks_q[head.pos];
	assign out_valid   = out_valid_q;
	assign out_beat    = out_beat_q;

	always_ff @(posedge clk) begin
		if (release_blk) begin
			ks_q <= core_ks;
		end
		if (pop) begin
			out_beat_q.text_out  <= (head.text ^ ks_word) & byte_mask(head.nbytes);
			out_beat_q.out_bytes <= head.nbytes;
			out_beat_q.out_last  <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: sim/tb_chacha20_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher
// Self-checking bench for the ChaCha20 stream cipher. A tracker class keeps
// its own key, nonce, counter and keystream state, predicts every output beat
// from the input beats it sees accepted, and compares the outputs field by
// field. Directed corner beats come first, then random messages, broken
// sequences and noise under several key and counter settings, with random
// stalls on both sides and a long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher;
	import chacha_pkg::*;

	localparam int DOUBLE_ROUNDS = 10;
	localparam int SETTLE_CYCLES = 2 * DOUBLE_ROUNDS + 10;
	localparam int DRAIN_LIMIT = 20000;
	localparam int LONG_HOLD = 300;

	class cipher_tracker;
		logic [63:0] key_q [4];
		logic [63:0] nonce_lo;
		logic [31:0] nonce_hi;
		logic [31:0] ctr_start;
		logic [31:0] blk_ctr;
		logic [63:0] ks_word [8];
		logic [2:0]  word_pos;
		logic [31:0] mixw [16];
		out_beat_t   expected_cipher [$];
		int          errors;

		function new();
			for (int k = 0; k < 4; k++) key_q[k] = '0;
			for (int k = 0; k < 8; k++) ks_word[k] = '0;
			nonce_lo = '0;
			nonce_hi = '0;
			ctr_start = '0;
			blk_ctr = '0;
			word_pos = '0;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [63:0] v);
			case (idx)
				REG_KEY0: key_q[0] = v;
				REG_KEY1: key_q[1] = v;
				REG_KEY2: key_q[2] = v;
				REG_KEY3: key_q[3] = v;
				REG_NONCE_LOW: nonce_lo = v;
				REG_NONCE_HIGH: nonce_hi = v[31:0];
				REG_INIT_CTR: ctr_start = v[31:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] rol(logic [31:0] x, int n);
			logic [63:0] t;
			t = {x, x} << n;
			return t[63:32];
		endfunction

		function void quarter_mix(int a, int b, int c, int d);
			mixw[a] = mixw[a] + mixw[b]; mixw[d] = rol(mixw[d] ^ mixw[a], 16);
			mixw[c] = mixw[c] + mixw[d]; mixw[b] = rol(mixw[b] ^ mixw[c], 12);
			mixw[a] = mixw[a] + mixw[b]; mixw[d] = rol(mixw[d] ^ mixw[a], 8);
			mixw[c] = mixw[c] + mixw[d]; mixw[b] = rol(mixw[b] ^ mixw[c], 7);
		endfunction

		function void next_block();
			logic [31:0] init_w [16];
			init_w[0] = SIGMA0;
			init_w[1] = SIGMA1;
			init_w[2] = SIGMA2;
			init_w[3] = SIGMA3;
			for (int k = 0; k < 4; k++) begin
				init_w[4 + 2 * k] = key_q[k][31:0];
				init_w[5 + 2 * k] = key_q[k][63:32];
			end
			init_w[12] = blk_ctr;
			init_w[13] = nonce_lo[31:0];
			init_w[14] = nonce_lo[63:32];
			init_w[15] = nonce_hi;
			mixw = init_w;
			for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
				quarter_mix(0, 4, 8, 12);
				quarter_mix(1, 5, 9, 13);
				quarter_mix(2, 6, 10, 14);
				quarter_mix(3, 7, 11, 15);
				quarter_mix(0, 5, 10, 15);
				quarter_mix(1, 6, 11, 12);
				quarter_mix(2, 7, 8, 13);
				quarter_mix(3, 4, 9, 14);
			end
			for (int k = 0; k < 8; k++) begin
				ks_word[k] = {mixw[2 * k + 1] + init_w[2 * k + 1], mixw[2 * k] + init_w[2 * k]};
			end
			blk_ctr = blk_ctr + 32'd1;
		endfunction

		function void note_word(in_beat_t b);
			logic [3:0]  n;
			logic [63:0] mask;
			out_beat_t   e;
			n = b.valid_bytes;
			if (n == 4'd0) begin
				n = 4'd1;
			end else if (n > 4'd8) begin
				n = 4'd8;
			end
			if (b.first) begin
				blk_ctr = ctr_start;
				word_pos = '0;
			end
			if (word_pos == 3'd0) next_block();
			mask = '1;
			if (n < 4'd8) mask = (64'd1 << (8 * n)) - 64'd1;
			e.text_out = (b.text_in ^ ks_word[word_pos]) & mask;
			e.out_bytes = n;
			e.out_last = b.last;
			word_pos = b.last ? 3'd0 : word_pos + 3'd1;
			expected_cipher.push_back(e);
		endfunction

		function void check_word(out_beat_t got);
			out_beat_t want;
			if (expected_cipher.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_cipher.pop_front();
			if (got.text_out !== want.text_out) begin
				$display("%0t: text_out expected %h actual %h", $time, want.text_out,
					got.text_out);
				errors++;
			end
			if (got.out_bytes !== want.out_bytes) begin
				$display("%0t: out_bytes expected %0d actual %0d", $time, want.out_bytes,
					got.out_bytes);
				errors++;
			end
			if (got.out_last !== want.out_last) begin
				$display("%0t: out_last expected %b actual %b", $time, want.out_last,
					got.out_last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_beat_t    in_beat;
	logic        out_valid;
	logic        out_ready;
	out_beat_t   out_beat;

	cipher_tracker sb;
	int words_sent;
	bit tx_idle_en;
	bit rx_idle_en;
	bit idle_allowed;
	bit long_hold_req;

	chacha20_stream_cipher #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat(out_beat)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// output side: random stalls plus one long hold on request
	initial begin
		int burst;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				burst = $urandom_range(1, 6);
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_word(out_beat);
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic hold_sender(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_word(logic [63:0] text, logic [3:0] nb, bit f, bit l);
		in_beat_t b;
		b.text_in = text;
		b.valid_bytes = nb;
		b.first = f;
		b.last = l;
		if (tx_idle_en && $urandom_range(0, 5) == 0) hold_sender($urandom_range(1, 6));
		@(negedge clk);
		in_valid <= 1'b1;
		in_beat <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_word(b);
		words_sent++;
	endtask

	task automatic send_message(int len, bit with_first, bit with_last, bit odd_sizes);
		logic [3:0] nb;
		for (int i = 0; i < len; i++) begin
			nb = (i == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
			if (odd_sizes) nb = 4'($urandom_range(0, 15));
			send_word(rnd64(), nb, with_first && i == 0, with_last && i == len - 1);
		end
	endtask

	// drop valid, wait for every expected beat, then let the core go quiet
	task automatic settle();
		int waited;
		waited = 0;
		hold_sender(1);
		while (sb.expected_cipher.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_settings(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
		logic [63:0] k3, logic [63:0] nl, logic [63:0] nh, logic [63:0] ic);
		settle();
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_NONCE_LOW, nl);
		write_reg(REG_NONCE_HIGH, nh);
		write_reg(REG_INIT_CTR, ic);
	endtask

	task automatic run_traffic(int target);
		int kind;
		int len;
		while (words_sent < target) begin
			kind = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
			tx_idle_en = idle_allowed && ($urandom_range(0, 3) != 0);
			rx_idle_en = idle_allowed && ($urandom_range(0, 3) != 0);
			if (kind < 75) begin
				send_message(len, 1'b1, 1'b1, 1'b0);
			end else if (kind < 87) begin
				send_message(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(rnd64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_beat = '0;
		words_sent = 0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		idle_allowed = 1'b1;
		long_hold_req = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word('0, 4'd8, 1'b1, 1'b1);
		send_word('1, 4'd8, 1'b1, 1'b0);
		send_word(rnd64(), 4'd0, 1'b0, 1'b0);
		send_word('1, 4'd15, 1'b0, 1'b0);
		send_word(rnd64(), 4'd9, 1'b0, 1'b0);
		send_word('0, 4'd1, 1'b0, 1'b0);
		send_word(rnd64(), 4'd2, 1'b0, 1'b0);
		send_word(rnd64(), 4'd3, 1'b0, 1'b0);
		send_word(rnd64(), 4'd4, 1'b0, 1'b0);
		send_word(rnd64(), 4'd5, 1'b0, 1'b0);
		send_word(rnd64(), 4'd6, 1'b0, 1'b0);
		send_word('1, 4'd7, 1'b0, 1'b1);
		send_word(rnd64(), 4'd8, 1'b0, 1'b0);
		send_word(rnd64(), 4'd5, 1'b0, 1'b1);
		send_word(rnd64(), 4'd3, 1'b1, 1'b1);
		load_settings('1, '1, '1, '1, '1, '1, '1);
		send_message(9, 1'b1, 1'b1, 1'b0);

		load_settings(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
			{$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 2))});
		run_traffic(450);

		load_settings(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
		long_hold_req = 1'b1;
		tx_idle_en = 1'b0;
		send_message(40, 1'b1, 1'b1, 1'b0);
		run_traffic(800);

		load_settings('0, '0, '0, '0, '0, '0, '0);
		run_traffic(1100);

		load_settings(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
		run_traffic(1500);

		load_settings(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
		idle_allowed = 1'b0;
		run_traffic(1900);

		settle();
		if (sb.expected_cipher.size() != 0) begin
			$display("%0t: %0d expected beats never arrived", $time,
				sb.expected_cipher.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/chacha_pkg.sv
rtl/core/chacha_front.sv
rtl/core/chacha_fifo.sv
rtl/core/chacha_core.sv
rtl/core/chacha_back.sv
rtl/core/chacha20_stream_cipher.sv
sim/tb_chacha20_stream_cipher.sv
